// ----- rtl/core/dec32_pkg.sv -----
// Package for the decimal32 arithmetic unit.
// Holds the shared types, constants and the field decode/encode functions.
// Depends on nothing.
package dec32_pkg;

  // datapath width of the shared adder and the working registers
  localparam int W = 30;

  localparam int unsigned BIAS     = 95;
  localparam int unsigned COEF_MAX = 9999999;
  localparam int          EXP_MIN  = -95;
  localparam int          EXP_MAX  = 96;
  localparam int unsigned DIG_TOP  = 1000000;

  // saturation level: anything at or above it can never come back into range
  localparam logic [W-1:0] CAP = W'(1) << 25;

  localparam logic [4:0] COMB_INF = 5'd30;
  localparam logic [4:0] COMB_NAN = 5'd31;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_FIN,
    K_INF,
    K_NAN
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_A_ALN,
    ST_A_SUM,
    ST_A_NEG,
    ST_MUL,
    ST_N1,
    ST_N1M,
    ST_N2,
    ST_N2C,
    ST_D_SUB,
    ST_D_ACC,
    ST_D_Q10,
    ST_D_R10,
    ST_FIN
  } state_t;

  // adder control from the sequencer
  typedef struct packed {
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         sub;
  } alu_ctl_t;

  // adder result back to the sequencer
  typedef struct packed {
    logic [W-1:0] res;
    logic         borrow;
  } alu_res_t;

  function automatic logic [23:0] dec_coef(input logic [31:0] w);
    logic [4:0] comb;
    comb = w[30:26];
    if (comb[4:3] == 2'b11) begin
      return {1'b1, 2'b00, comb[0], w[19:0]};
    end
    return {1'b0, comb[2:0], w[19:0]};
  endfunction

  function automatic logic signed [8:0] dec_exp(input logic [31:0] w);
    logic [4:0] comb;
    logic [1:0] hi;
    comb = w[30:26];
    hi   = (comb[4:3] == 2'b11) ? comb[2:1] : comb[4:3];
    return $signed({1'b0, hi, w[25:20]}) - 9'sd95;
  endfunction

  function automatic logic [31:0] enc_special(input logic s, input logic [4:0] comb);
    return {s, comb, 26'd0};
  endfunction

  // canonical finite encoding, range already checked
  function automatic logic [31:0] enc_finite(input logic s, input logic signed [9:0] e,
                                             input logic [23:0] c);
    logic [9:0] be;
    logic [4:0] comb;
    be = 10'(e + 10'sd95);
    if (c[23]) begin
      comb = {2'b11, be[7:6], c[20]};
    end else begin
      comb = {be[7:6], c[22:20]};
    end
    return {s, comb, be[5:0], c[19:0]};
  endfunction

endpackage

// ----- rtl/core/dec32_alu.sv -----
// Shared add/subtract unit of the decimal32 arithmetic unit.
// Depends on dec32_pkg for the width and the control/result structs.
module dec32_alu (
  input  dec32_pkg::alu_ctl_t ctl,
  output dec32_pkg::alu_res_t rsl
);

  logic [dec32_pkg::W:0]   sum;
  logic [dec32_pkg::W-1:0] b_op;

  // subtract as a + ~b + 1; carry out low means a < b
  assign b_op = ctl.sub ? ~ctl.b : ctl.b;
  assign sum  = {1'b0, ctl.a} + {1'b0, b_op} + {{dec32_pkg::W{1'b0}}, ctl.sub};

  assign rsl.res    = sum[dec32_pkg::W-1:0];
  assign rsl.borrow = ctl.sub & ~sum[dec32_pkg::W];

endmodule

// ----- rtl/core/decimal32_arithmetic_unit.sv -----
// Decimal32 arithmetic unit; NaN/Inf operands and a zero divide operand go straight to the result,
// add/sub uses up to 8 alignment steps, multiply 24 shift-add steps, divide a normalization, then
// up to nine subtractions per digit, seven digits at most.
// One item at a time with busy high; the next item is taken at the edge that takes the result.
// Results cannot be stalled: out_valid is a one-cycle strobe.
// Synchronous active-low reset returns the sequencer to idle and clears the strobe.
module decimal32_arithmetic_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result
);

  localparam int W = dec32_pkg::W;

  dec32_pkg::state_t state_r, state_nxt;
  dec32_pkg::op_t    op_r;
  dec32_pkg::kind_t  kind_r;
  dec32_pkg::alu_ctl_t alu_ctl;
  dec32_pkg::alu_res_t alu_rsl;

  logic [31:0]        a_r, b_r;
  logic [W-1:0]       x_r, y_r, t_r, q_r;
  logic               sign_r, scale_a_r;
  logic signed [9:0]  e_r;
  logic signed [5:0]  adj_r;
  logic [7:0]         cnt_r;
  logic [3:0]         digit_r;
  logic               out_valid_r;
  logic [31:0]        out_result_r;

  // operand decode
  logic               sa, sb, nan_any, inf_any;
  logic [23:0]        ca, cb;
  logic signed [8:0]  ea, eb;
  logic signed [9:0]  d_ab;
  logic [W-1:0]       aln_v, clamped;
  logic               aln_done, div_stop;
  logic signed [9:0]  e_fin;
  logic               ovf;

  assign sa      = a_r[31];
  assign sb      = b_r[31];
  assign ca      = dec32_pkg::dec_coef(a_r);
  assign cb      = dec32_pkg::dec_coef(b_r);
  assign ea      = dec32_pkg::dec_exp(a_r);
  assign eb      = dec32_pkg::dec_exp(b_r);
  assign nan_any = (a_r[30:26] == dec32_pkg::COMB_NAN) || (b_r[30:26] == dec32_pkg::COMB_NAN);
  assign inf_any = (a_r[30:26] == dec32_pkg::COMB_INF) || (b_r[30:26] == dec32_pkg::COMB_INF);
  assign d_ab    = 10'(ea) - 10'(eb);

  // alignment: stop on count done, zero value or saturation
  assign aln_v    = scale_a_r ? x_r : y_r;
  assign aln_done = (cnt_r == 8'd0) || (aln_v == '0) || (aln_v >= dec32_pkg::CAP);
  assign clamped  = (alu_rsl.res >= dec32_pkg::CAP) ? dec32_pkg::CAP : alu_rsl.res;

  // long division stop after accumulating a digit
  assign div_stop = ((x_r == '0) && (adj_r >= 6'sd0)) ||
                    (alu_rsl.res >= W'(dec32_pkg::DIG_TOP));

  // final range check
  assign e_fin = e_r - 10'(adj_r);
  assign ovf   = (e_fin < 10'(dec32_pkg::EXP_MIN)) || (e_fin > 10'(dec32_pkg::EXP_MAX)) ||
                 (q_r > W'(dec32_pkg::COEF_MAX));

  dec32_alu u_alu (
    .ctl (alu_ctl),
    .rsl (alu_rsl)
  );

  // adder operand select per state
  always_comb begin
    alu_ctl = '{a: '0, b: '0, sub: 1'b0};
    unique case (state_r)
      dec32_pkg::ST_A_ALN: alu_ctl = '{a: aln_v << 3, b: aln_v << 1, sub: 1'b0};
      dec32_pkg::ST_A_SUM: alu_ctl = '{a: x_r, b: y_r, sub: sa ^ sb};
      dec32_pkg::ST_A_NEG: alu_ctl = '{a: y_r, b: x_r, sub: 1'b1};
      dec32_pkg::ST_MUL:   alu_ctl = '{a: q_r << 1, b: (y_r[23] ? x_r : '0), sub: 1'b0};
      dec32_pkg::ST_N1:    alu_ctl = '{a: x_r, b: y_r, sub: 1'b1};
      dec32_pkg::ST_N1M:   alu_ctl = '{a: x_r << 3, b: x_r << 1, sub: 1'b0};
      dec32_pkg::ST_N2:    alu_ctl = '{a: y_r << 3, b: y_r << 1, sub: 1'b0};
      dec32_pkg::ST_N2C:   alu_ctl = '{a: x_r, b: t_r, sub: 1'b1};
      dec32_pkg::ST_D_SUB: alu_ctl = '{a: x_r, b: y_r, sub: 1'b1};
      dec32_pkg::ST_D_ACC: alu_ctl = '{a: q_r, b: W'(digit_r), sub: 1'b0};
      dec32_pkg::ST_D_Q10: alu_ctl = '{a: q_r << 3, b: q_r << 1, sub: 1'b0};
      dec32_pkg::ST_D_R10: alu_ctl = '{a: x_r << 3, b: x_r << 1, sub: 1'b0};
      default:             alu_ctl = '{a: '0, b: '0, sub: 1'b0};
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dec32_pkg::ST_IDLE: if (start) state_nxt = dec32_pkg::ST_DEC;
      dec32_pkg::ST_DEC: begin
        if (nan_any || inf_any) begin
          state_nxt = dec32_pkg::ST_FIN;
        end else begin
          unique case (op_r)
            dec32_pkg::OP_ADD, dec32_pkg::OP_SUB: state_nxt = dec32_pkg::ST_A_ALN;
            dec32_pkg::OP_MUL: state_nxt = dec32_pkg::ST_MUL;
            default: state_nxt = ((cb == '0) || (ca == '0)) ? dec32_pkg::ST_FIN
                                                            : dec32_pkg::ST_N1;
          endcase
        end
      end
      dec32_pkg::ST_A_ALN: if (aln_done) state_nxt = dec32_pkg::ST_A_SUM;
      dec32_pkg::ST_A_SUM: state_nxt = alu_rsl.borrow ? dec32_pkg::ST_A_NEG : dec32_pkg::ST_FIN;
      dec32_pkg::ST_A_NEG: state_nxt = dec32_pkg::ST_FIN;
      dec32_pkg::ST_MUL:   if (cnt_r == 8'd1) state_nxt = dec32_pkg::ST_FIN;
      dec32_pkg::ST_N1:    state_nxt = alu_rsl.borrow ? dec32_pkg::ST_N1M : dec32_pkg::ST_N2;
      dec32_pkg::ST_N1M:   state_nxt = dec32_pkg::ST_N1;
      dec32_pkg::ST_N2:    state_nxt = dec32_pkg::ST_N2C;
      dec32_pkg::ST_N2C:   state_nxt = alu_rsl.borrow ? dec32_pkg::ST_D_SUB : dec32_pkg::ST_N2;
      dec32_pkg::ST_D_SUB: if (alu_rsl.borrow) state_nxt = dec32_pkg::ST_D_ACC;
      dec32_pkg::ST_D_ACC: state_nxt = div_stop ? dec32_pkg::ST_FIN : dec32_pkg::ST_D_Q10;
      dec32_pkg::ST_D_Q10: state_nxt = dec32_pkg::ST_D_R10;
      dec32_pkg::ST_D_R10: state_nxt = dec32_pkg::ST_D_SUB;
      dec32_pkg::ST_FIN:   state_nxt = dec32_pkg::ST_IDLE;
      default:             state_nxt = dec32_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dec32_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == dec32_pkg::ST_FIN);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      dec32_pkg::ST_IDLE: begin
        if (start) begin
          op_r <= dec32_pkg::op_t'(in_operation);
          a_r  <= in_operand_a;
          b_r  <= in_operand_b ^ {(in_operation == dec32_pkg::OP_SUB), 31'd0};
        end
      end
      dec32_pkg::ST_DEC: begin
        x_r    <= W'(ca);
        y_r    <= W'(cb);
        q_r    <= '0;
        adj_r  <= '0;
        unique case (op_r)
          dec32_pkg::OP_ADD, dec32_pkg::OP_SUB: begin
            sign_r    <= sa;
            kind_r    <= nan_any ? dec32_pkg::K_NAN :
                         (inf_any ? dec32_pkg::K_INF : dec32_pkg::K_FIN);
            scale_a_r <= (d_ab > 10'sd0);
            cnt_r     <= (d_ab > 10'sd0) ? d_ab[7:0] : 8'(-d_ab);
            e_r       <= (d_ab > 10'sd0) ? 10'(eb) : 10'(ea);
          end
          dec32_pkg::OP_MUL: begin
            sign_r <= nan_any || inf_any ? 1'b0 : (sa ^ sb);
            kind_r <= nan_any ? dec32_pkg::K_NAN :
                      (inf_any ? dec32_pkg::K_INF : dec32_pkg::K_FIN);
            cnt_r  <= 8'd24;
            e_r    <= 10'(ea) + 10'(eb);
          end
          default: begin
            digit_r <= '0;
            // 0/0 is NaN, x/0 is Inf, 0/x is +0
            if (nan_any || (cb == '0 && ca == '0)) begin
              kind_r <= dec32_pkg::K_NAN;
            end else if (inf_any || cb == '0) begin
              kind_r <= dec32_pkg::K_INF;
            end else begin
              kind_r <= dec32_pkg::K_FIN;
            end
            if (nan_any || inf_any || cb == '0 || ca == '0) begin
              sign_r <= 1'b0;
              e_r    <= '0;
            end else begin
              sign_r <= sa ^ sb;
              e_r    <= 10'(ea) - 10'(eb);
            end
          end
        endcase
      end
      dec32_pkg::ST_A_ALN: begin
        if (!aln_done) begin
          if (scale_a_r) x_r <= clamped;
          else           y_r <= clamped;
          cnt_r <= cnt_r - 8'd1;
        end
      end
      dec32_pkg::ST_A_SUM: begin
        q_r <= alu_rsl.res;
        if ((sa != sb) && (alu_rsl.res == '0)) sign_r <= sb;
      end
      dec32_pkg::ST_A_NEG: begin
        q_r    <= alu_rsl.res;
        sign_r <= sb;
      end
      dec32_pkg::ST_MUL: begin
        q_r   <= clamped;
        y_r   <= y_r << 1;
        cnt_r <= cnt_r - 8'd1;
      end
      dec32_pkg::ST_N1M: begin
        x_r   <= alu_rsl.res;
        adj_r <= adj_r + 6'sd1;
      end
      dec32_pkg::ST_N2: t_r <= alu_rsl.res;
      dec32_pkg::ST_N2C: begin
        if (!alu_rsl.borrow) begin
          y_r   <= t_r;
          adj_r <= adj_r - 6'sd1;
        end
      end
      dec32_pkg::ST_D_SUB: begin
        if (!alu_rsl.borrow) begin
          x_r     <= alu_rsl.res;
          digit_r <= digit_r + 4'd1;
        end
      end
      dec32_pkg::ST_D_ACC: begin
        q_r     <= alu_rsl.res;
        digit_r <= '0;
      end
      dec32_pkg::ST_D_Q10: q_r <= alu_rsl.res;
      dec32_pkg::ST_D_R10: begin
        x_r   <= alu_rsl.res;
        adj_r <= adj_r + 6'sd1;
      end
      dec32_pkg::ST_FIN: begin
        priority if (kind_r == dec32_pkg::K_NAN) begin
          out_result_r <= dec32_pkg::enc_special(sign_r, dec32_pkg::COMB_NAN);
        end else if (kind_r == dec32_pkg::K_INF || ovf) begin
          out_result_r <= dec32_pkg::enc_special(sign_r, dec32_pkg::COMB_INF);
        end else begin
          out_result_r <= dec32_pkg::enc_finite(sign_r, e_fin, q_r[23:0]);
        end
      end
      default: ;
    endcase
  end

  assign busy       = (state_r != dec32_pkg::ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

`ifndef SYNTH
  a_strobe_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == dec32_pkg::ST_FIN))
    else $error("result strobe without finishing step");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == dec32_pkg::ST_IDLE || state_r == dec32_pkg::ST_DEC))
    else $error("result strobe while work in progress");
  a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dec32_pkg::ST_MUL) |-> (cnt_r != 8'd0))
    else $error("multiply step counter ran out");
`endif

endmodule
